/* sv/ring_queue_with_event_triples_top_defines.svh */
// ----------------------------------------------------------------------------
// Ring queue assertion macros
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RING_QUEUE_WITH_EVENT_TRIPLES_TOP_DEFINES_SVH
`define RING_QUEUE_WITH_EVENT_TRIPLES_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RQET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RQET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/rqet_pkg.sv */
// ----------------------------------------------------------------------------
// Ring queue package
// Action and status codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package rqet_pkg;

  localparam int CNT_W  = 7;
  localparam int DATA_W = 32;

  // Number of words moved by one event transfer.
  localparam logic [CNT_W-1:0] EVT_WORDS = 7'd3;

  typedef enum logic [2:0] {
    ACT_PUSH    = 3'd0,
    ACT_POP     = 3'd1,
    ACT_PUSH_EV = 3'd2,
    ACT_POP_EV  = 3'd3,
    ACT_QUERY   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_REPORT
  } state_t;

endpackage

/* sv/ring_queue_with_event_triples_top.sv */
// ----------------------------------------------------------------------------
// Ring queue with event triples
// Circular word queue with single-word and three-word event transfers.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  --------  ----------------------  ------------------------------------------
//  command   start / busy            action, word_a, word_b, word_c
//  result    done (one per result)   data_word, status, stored_count, last
//  config    size_in_use_we          size_in_use
//
// A command transfer happens on a rising edge with start high and busy low.
// Words move one a cycle through the store, which has one write and one
// read port; one index stepper is shared by both queue pointers. A new
// command can be taken before the last result of a pop has been shown.
// Each result is shown for exactly one cycle with done high and the
// receiver cannot stall it. Reset is synchronous and active high; it
// empties the queue and selects the largest size in use. The store needs
// no clearing.
// ----------------------------------------------------------------------------
`include "ring_queue_with_event_triples_top_defines.svh"

module ring_queue_with_event_triples_top
  import rqet_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        action,
  input  logic [DATA_W-1:0] word_a,
  input  logic [DATA_W-1:0] word_b,
  input  logic [DATA_W-1:0] word_c,
  input  logic              size_in_use_we,
  input  logic [CNT_W-1:0]  size_in_use,
  output logic              done,
  output logic [DATA_W-1:0] data_word,
  output logic [1:0]        status,
  output logic [CNT_W-1:0]  stored_count,
  output logic              last
);

  localparam int IDX_W = $clog2(DEPTH);
  // The size register is seven bits wide, so the size in use tops out there.
  localparam int SIZE_MAX_I = (DEPTH > 127) ? 127 : DEPTH;
  localparam logic [CNT_W-1:0] SIZE_MAX = CNT_W'(SIZE_MAX_I);

  // Sequencer and queue bookkeeping.
  state_t           state, state_next;
  logic [1:0]       cnt, cnt_next;
  logic [1:0]       wsel, wsel_next;
  logic [CNT_W-1:0] size_reg, size_next;
  logic [CNT_W-1:0] free_slots, free_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  logic [IDX_W-1:0] wr_idx, wr_idx_next;
  status_t          rep_status, rep_status_next;
  logic             rd_pend;
  logic             rd_last;

  // Words of the command in flight.
  logic [DATA_W-1:0] word_a_q, word_b_q, word_c_q;

  logic              accept;
  logic [CNT_W-1:0]  stored;
  logic [CNT_W-1:0]  size_clamped;
  logic [IDX_W-1:0]  step_in, step_out;
  logic              ram_we;
  logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;
  logic              rd_issue;
  logic              rd_last_issue;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign stored = size_reg - free_slots;

  // A size of zero means one slot; anything above SIZE_MAX is clamped to it.
  always_comb begin
    if (size_in_use == '0) begin
      size_clamped = CNT_W'(1);
    end else if (size_in_use > SIZE_MAX) begin
      size_clamped = SIZE_MAX;
    end else begin
      size_clamped = size_in_use;
    end
  end

  // The next word of an event goes out in word_a, word_b, word_c order.
  always_comb begin
    case (wsel)
      2'd0:    ram_wdata = WORD_WIDTH'(word_a_q);
      2'd1:    ram_wdata = WORD_WIDTH'(word_b_q);
      default: ram_wdata = WORD_WIDTH'(word_c_q);
    endcase
  end

  // One stepper serves both pointers: reads in the read state, writes
  // otherwise.
  assign step_in = (state == S_READ) ? rd_idx : wr_idx;

  rqet_step #(
    .IDX_W (IDX_W)
  ) u_step (
    .idx      (step_in),
    .size     (size_reg),
    .idx_next (step_out)
  );

  rqet_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (ram_wdata),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // Sequencer. The free-slot count moves to its final value as soon as a
  // command is taken, so every result of that command reports the count left
  // behind by the whole action. Words then move one per cycle.
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    wsel_next       = wsel;
    size_next       = size_reg;
    free_next       = free_slots;
    rd_idx_next     = rd_idx;
    wr_idx_next     = wr_idx;
    rep_status_next = rep_status;
    ram_we          = 1'b0;
    rd_issue        = 1'b0;
    rd_last_issue   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          rep_status_next = STATUS_OK;
          wsel_next       = 2'd0;
          unique case (action)
            ACT_PUSH: begin
              if (free_slots != '0) begin
                free_next  = free_slots - CNT_W'(1);
                cnt_next   = 2'd1;
                state_next = S_WRITE;
              end else begin
                rep_status_next = STATUS_FULL;
                state_next      = S_REPORT;
              end
            end
            ACT_PUSH_EV: begin
              if (free_slots >= EVT_WORDS) begin
                free_next  = free_slots - EVT_WORDS;
                cnt_next   = 2'(EVT_WORDS);
                state_next = S_WRITE;
              end else begin
                rep_status_next = STATUS_FULL;
                state_next      = S_REPORT;
              end
            end
            ACT_POP: begin
              if (stored != '0) begin
                free_next  = free_slots + CNT_W'(1);
                cnt_next   = 2'd1;
                state_next = S_READ;
              end else begin
                rep_status_next = STATUS_EMPTY;
                state_next      = S_REPORT;
              end
            end
            ACT_POP_EV: begin
              if (stored >= EVT_WORDS) begin
                free_next  = free_slots + EVT_WORDS;
                cnt_next   = 2'(EVT_WORDS);
                state_next = S_READ;
              end else begin
                rep_status_next = STATUS_EMPTY;
                state_next      = S_REPORT;
              end
            end
            // Query and the unused codes report the count only.
            default: begin
              state_next = S_REPORT;
            end
          endcase
        end
      end
      S_WRITE: begin
        ram_we      = 1'b1;
        wr_idx_next = step_out;
        wsel_next   = wsel + 2'd1;
        cnt_next    = cnt - 2'd1;
        if (cnt == 2'd1) begin
          state_next = S_REPORT;
        end
      end
      S_READ: begin
        rd_issue      = 1'b1;
        rd_last_issue = (cnt == 2'd1);
        rd_idx_next   = step_out;
        cnt_next      = cnt - 2'd1;
        if (cnt == 2'd1) begin
          state_next = S_IDLE;
        end
      end
      S_REPORT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A size write empties the queue; user sends it only while idle, unchecked.
    if (size_in_use_we) begin
      size_next   = size_clamped;
      free_next   = size_clamped;
      rd_idx_next = '0;
      wr_idx_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= 2'd0;
      wsel       <= 2'd0;
      size_reg   <= SIZE_MAX;
      free_slots <= SIZE_MAX;
      rd_idx     <= '0;
      wr_idx     <= '0;
      rep_status <= STATUS_OK;
      rd_pend    <= 1'b0;
      rd_last    <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      wsel       <= wsel_next;
      size_reg   <= size_next;
      free_slots <= free_next;
      rd_idx     <= rd_idx_next;
      wr_idx     <= wr_idx_next;
      rep_status <= rep_status_next;
      rd_pend    <= rd_issue;
      rd_last    <= rd_last_issue;
      done       <= rd_pend || (state == S_REPORT);
    end
  end

  // Command words are captured on the transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      word_a_q <= word_a;
      word_b_q <= word_b;
      word_c_q <= word_c;
    end
  end

  // Result register. Read data appears in the cycle after its address, so a pop
  // result is loaded while the next read, if any, is already under way.
  always_ff @(posedge clk) begin
    stored_count <= stored;
    if (rd_pend) begin
      data_word <= DATA_W'(ram_rdata);
      status    <= STATUS_OK;
      last      <= rd_last;
    end else begin
      data_word <= '0;
      status    <= rep_status;
      last      <= 1'b1;
    end
  end

  `RQET_ASSERT_NOW(a_free_within_size, 1'b1, free_slots <= size_reg, "free slots exceed size in use")
  `RQET_ASSERT_NOW(a_refused_no_data, done && (status != STATUS_OK), data_word == '0, "refused action returned data")
  `RQET_ASSERT_NEXT(a_accept_goes_busy, accept, busy, "command transfer did not start the sequencer")
  `RQET_ASSERT_NOW(a_wr_idx_in_range, 1'b1, 32'(wr_idx) < 32'(size_reg), "write index beyond size in use")

endmodule

/* sv/rqet_ram.sv */
// ----------------------------------------------------------------------------
// Ring queue word store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rqet_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/rqet_step.sv */
// ----------------------------------------------------------------------------
// Ring queue index stepper
// Advances a queue index by one and wraps it at the size in use.
// ----------------------------------------------------------------------------
module rqet_step
  import rqet_pkg::*;
#(
  parameter int IDX_W = 6
) (
  input  logic [IDX_W-1:0] idx,
  input  logic [CNT_W-1:0] size,
  output logic [IDX_W-1:0] idx_next
);

  localparam int CW = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

  logic [CW-1:0] inc;

  assign inc      = CW'(idx) + CW'(1);
  assign idx_next = (inc >= CW'(size)) ? '0 : idx + IDX_W'(1);

endmodule

/* verif/ring_queue_mirror_pkg.sv */
// ----------------------------------------------------------------------------
// Ring queue mirror
// Transaction-level copy of the ring queue that predicts every result of a
// command and compares the results that the block produces against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package ring_queue_mirror_pkg;
  import rqet_pkg::*;

  localparam int QUEUE_DEPTH = 64;

  typedef struct {
    logic [DATA_W-1:0] data_word;
    status_t           status;
    logic [CNT_W-1:0]  stored_count;
    logic              last;
  } queue_result_t;

  class queue_mirror;
    logic [DATA_W-1:0] slots [QUEUE_DEPTH];
    int unsigned       size_in_use;
    int unsigned       rd_ptr;
    int unsigned       wr_ptr;
    int unsigned       free_slots;
    queue_result_t     pending_results [$];
    int unsigned       mismatches;

    function new();
      size_in_use = QUEUE_DEPTH;
      mismatches  = 0;
      flush();
    endfunction

    function void flush();
      rd_ptr     = 0;
      wr_ptr     = 0;
      free_slots = size_in_use;
    endfunction

    // A size of zero means one slot; anything above the depth means all of them.
    function void set_size(logic [CNT_W-1:0] value);
      int unsigned n;
      n = value;
      if (n < 1) n = 1;
      if (n > QUEUE_DEPTH) n = QUEUE_DEPTH;
      size_in_use = n;
      flush();
    endfunction

    function int unsigned words_held();
      return size_in_use - free_slots;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function void put_word(logic [DATA_W-1:0] w);
      slots[wr_ptr] = w;
      wr_ptr = (wr_ptr + 1 >= size_in_use) ? 0 : wr_ptr + 1;
      free_slots--;
    endfunction

    function logic [DATA_W-1:0] take_word();
      logic [DATA_W-1:0] w;
      w = slots[rd_ptr];
      rd_ptr = (rd_ptr + 1 >= size_in_use) ? 0 : rd_ptr + 1;
      free_slots++;
      return w;
    endfunction

    // The count carried by a result is the one after the whole command.
    function void add_result(logic [DATA_W-1:0] w, status_t st, logic lst);
      queue_result_t r;
      r.data_word    = w;
      r.status       = st;
      r.stored_count = CNT_W'(words_held());
      r.last         = lst;
      pending_results.push_back(r);
    endfunction

    function void note_command(logic [2:0] act, logic [DATA_W-1:0] a,
                               logic [DATA_W-1:0] b, logic [DATA_W-1:0] c);
      logic [DATA_W-1:0] w0, w1, w2;
      case (act)
        ACT_PUSH: begin
          if (free_slots == 0) begin
            add_result('0, STATUS_FULL, 1'b1);
          end else begin
            put_word(a);
            add_result('0, STATUS_OK, 1'b1);
          end
        end
        ACT_POP: begin
          if (words_held() == 0) begin
            add_result('0, STATUS_EMPTY, 1'b1);
          end else begin
            w0 = take_word();
            add_result(w0, STATUS_OK, 1'b1);
          end
        end
        ACT_PUSH_EV: begin
          if (free_slots < EVT_WORDS) begin
            add_result('0, STATUS_FULL, 1'b1);
          end else begin
            put_word(a);
            put_word(b);
            put_word(c);
            add_result('0, STATUS_OK, 1'b1);
          end
        end
        ACT_POP_EV: begin
          if (words_held() < EVT_WORDS) begin
            add_result('0, STATUS_EMPTY, 1'b1);
          end else begin
            w0 = take_word();
            w1 = take_word();
            w2 = take_word();
            add_result(w0, STATUS_OK, 1'b0);
            add_result(w1, STATUS_OK, 1'b0);
            add_result(w2, STATUS_OK, 1'b1);
          end
        end
        default: begin
          add_result('0, STATUS_OK, 1'b1);
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [DATA_W-1:0] d, logic [1:0] st, logic [CNT_W-1:0] cnt,
                      logic lst);
      queue_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result data=%h status=%0d count=%0d last=%b",
                                  d, st, cnt, lst));
        return;
      end
      want = pending_results.pop_front();
      if (d !== want.data_word || st !== want.status || cnt !== want.stored_count ||
          lst !== want.last) begin
        report_mismatch($sformatf(
          "got data=%h status=%0d count=%0d last=%b, wanted data=%h status=%0d count=%0d last=%b",
          d, st, cnt, lst, want.data_word, want.status, want.stored_count, want.last));
      end
    endtask
  endclass

endpackage

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Ring queue with event triples testbench
// Drives word and event commands through the start/busy port, changes the
// size in use between phases, and checks every result strobe against a
// mirror of the queue kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import rqet_pkg::*;
  import ring_queue_mirror_pkg::*;

  // Cycles without any transfer or result before the run is declared hung.
  // The sender gap is capped well below this limit, so a healthy block never
  // gets close.
  localparam int IDLE_LIMIT    = 1000;
  localparam int MAX_GAP       = 40;
  // Quiet cycles after the last result before touching the size register.
  localparam int SETTLE_CYCLES = 8;

  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic              start          = 1'b0;
  logic [2:0]        action         = ACT_QUERY;
  logic [DATA_W-1:0] word_a         = '0;
  logic [DATA_W-1:0] word_b         = '0;
  logic [DATA_W-1:0] word_c         = '0;
  logic              size_in_use_we = 1'b0;
  logic [CNT_W-1:0]  size_in_use    = CNT_W'(QUEUE_DEPTH);

  logic              busy;
  logic              done;
  logic [DATA_W-1:0] data_word;
  logic [1:0]        status;
  logic [CNT_W-1:0]  stored_count;
  logic              last;

  queue_mirror mirror;
  int unsigned idle_pct;
  int          quiet_cycles;

  ring_queue_with_event_triples_top #(
    .DEPTH      (QUEUE_DEPTH),
    .WORD_WIDTH (DATA_W)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .word_a         (word_a),
    .word_b         (word_b),
    .word_c         (word_c),
    .size_in_use_we (size_in_use_we),
    .size_in_use    (size_in_use),
    .done           (done),
    .data_word      (data_word),
    .status         (status),
    .stored_count   (stored_count),
    .last           (last)
  );

  always #1 clk = ~clk;

  // Result monitor and hang watchdog. Outputs are read right after the rising
  // edge, before the block's own updates for that edge land, so what is seen
  // here is exactly what the edge captured. A result cannot be held off, so
  // every done cycle is a transfer and goes straight to the mirror.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done) begin
        mirror.check_result(data_word, status, stored_count, last);
      end
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("[%0t] timeout: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("** ring_queue_with_event_triples_top: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Presents one command and holds it until the block takes it. Start is only
  // dropped when the sender decides to idle, so back-to-back commands keep
  // start high across the boundary without a glitch in the same time step.
  task send_command(logic [2:0] act, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                    logic [DATA_W-1:0] c);
    int n;
    n = 0;
    while (n < MAX_GAP && $urandom_range(0, 99) < idle_pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
    start  <= 1'b1;
    action <= act;
    word_a <= a;
    word_b <= b;
    word_c <= c;
    do @(posedge clk); while (busy);
    // The command transferred at this edge; predict what it will produce.
    mirror.note_command(act, a, b, c);
  endtask

  // Waits until every predicted result has come back and the block reports
  // itself free, then lets a few more cycles pass so that any trailing work
  // of the last command is over before the size register is touched.
  task drain_queue_results();
    start <= 1'b0;
    while (mirror.outstanding() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writing the size empties the queue in the block and in the mirror alike.
  task write_size(logic [CNT_W-1:0] value);
    size_in_use_we <= 1'b1;
    size_in_use    <= value;
    @(posedge clk);
    size_in_use_we <= 1'b0;
    mirror.set_size(value);
  endtask

  // One random command. Most traffic is pushes and pops of words and events
  // with random payload; a forced push bias fills the queue, otherwise the
  // mix leans toward whichever direction brings the fill back to the middle
  // so that both the full and the empty refusals keep showing up. A few
  // commands are queries or spare action codes, which behave as queries.
  task random_command(int unsigned push_bias);
    int unsigned bias;
    logic [2:0]  act;
    logic        is_push;
    logic        is_event;
    if ($urandom_range(0, 99) < 5) begin
      act = 3'($urandom_range(ACT_QUERY, ACT_QUERY + 3));
    end else begin
      if (push_bias != 0) begin
        bias = push_bias;
      end else begin
        bias = (mirror.words_held() * 2 < mirror.size_in_use) ? 65 : 35;
      end
      is_push  = ($urandom_range(0, 99) < bias);
      is_event = 1'($urandom_range(0, 1));
      if (is_push) begin
        act = is_event ? ACT_PUSH_EV : ACT_PUSH;
      end else begin
        act = is_event ? ACT_POP_EV : ACT_POP;
      end
    end
    send_command(act, $urandom, $urandom, $urandom);
  endtask

  // A phase starts from an empty, idle block with a fresh size setting and
  // its own amount of sender idling.
  task run_phase(logic [CNT_W-1:0] size_code, int unsigned idle, int unsigned items,
                 int unsigned push_bias);
    drain_queue_results();
    write_size(size_code);
    idle_pct = idle;
    repeat (items) random_command(push_bias);
  endtask

  initial begin
    mirror   = new();
    idle_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset size of 64: refusals on an empty queue, a
    // pop event with only two words stored, word and event traffic with
    // all-zero and all-one payloads, and the three spare action codes.
    send_command(ACT_QUERY,   32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_command(ACT_POP,     32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_command(ACT_POP_EV,  32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_command(ACT_PUSH,    32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_command(ACT_PUSH,    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(ACT_POP_EV,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_command(ACT_PUSH_EV, 32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
    send_command(ACT_POP_EV,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_command(ACT_POP,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_command(ACT_POP,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_command(ACT_POP,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    for (int k = 1; k <= 3; k++) begin
      send_command(3'(ACT_QUERY + k), 32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF);
    end

    // A size of zero is taken as a single slot: one push fills it, and an
    // event can neither be stored nor popped.
    drain_queue_results();
    write_size('0);
    send_command(ACT_PUSH,    32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_command(ACT_PUSH,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_command(ACT_PUSH_EV, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
    send_command(ACT_POP_EV,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_command(ACT_POP,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_command(ACT_POP,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

    // Three slots: an event is refused with only two free, then one fits and
    // comes back out across the wrap of the indexes.
    drain_queue_results();
    write_size(CNT_W'(EVT_WORDS));
    send_command(ACT_PUSH,    32'hCAFE_F00D, 32'h0000_0000, 32'h0000_0000);
    send_command(ACT_PUSH_EV, 32'h4444_4444, 32'h5555_5555, 32'h6666_6666);
    send_command(ACT_POP,     32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_command(ACT_PUSH_EV, 32'h7777_7777, 32'h8888_8888, 32'h9999_9999);
    send_command(ACT_POP_EV,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

    // Random phases. The first fills the full 64-slot queue without any
    // idling; the second has five slots and a mostly idle sender; the
    // all-ones size code is clamped to the depth; the last uses a random
    // small size with the sender idling a little over a third of the time.
    run_phase(CNT_W'(QUEUE_DEPTH), 0, 40, 85);
    run_phase(CNT_W'(5), 82, 30, 0);
    run_phase('1, 0, 30, 0);
    run_phase(CNT_W'($urandom_range(EVT_WORDS, 20)), 37, 35, 0);

    drain_queue_results();
    if (mirror.mismatches == 0) begin
      $display("** ring_queue_with_event_triples_top: PASSED **");
    end else begin
      $display("** ring_queue_with_event_triples_top: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/rqet_pkg.sv
sv/rqet_ram.sv
sv/rqet_step.sv
sv/ring_queue_with_event_triples_top.sv
verif/ring_queue_mirror_pkg.sv
verif/tb_top.sv
